FILE: hw/rtl/wbps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner package
// Shared constants, register indexes, check kind codes and the structs that
// travel between the scanner modules.
// ----------------------------------------------------------------------------
package wbps_pkg;

   localparam int DEFAULT_WINDOW_BYTES  = 64;
   localparam int DEFAULT_MAX_SIGNATURE = 8;
   localparam int CSR_DATA_W            = 64;
   localparam int CSR_INDEX_W           = 3;
   localparam int SPAN_W                = 7;

   localparam logic [CSR_INDEX_W-1:0] REG_SIGNATURE_BYTES  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_WILDCARD_MASK    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SIGNATURE_LENGTH = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ALIGNMENT        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_RESULT_LIMIT     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_CHECK_KIND       = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_CHECK_OFFSET     = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_CHECK_VALUE      = 3'd7;

   localparam logic [2:0] CHECK_NONE    = 3'd0;
   localparam logic [2:0] CHECK_EQ_BYTE = 3'd1;
   localparam logic [2:0] CHECK_EQ_HALF = 3'd2;
   localparam logic [2:0] CHECK_EQ_WORD = 3'd3;
   localparam logic [2:0] CHECK_NE_BYTE = 3'd4;
   localparam logic [2:0] CHECK_NE_HALF = 3'd5;
   localparam logic [2:0] CHECK_NE_WORD = 3'd6;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [31:0] byte_address;
      logic        region_first;
      logic        new_scan;
   } req_type;

   typedef struct packed {
      logic [31:0] match_address;
      logic        limit_reached;
   } rsp_type;

   typedef struct packed {
      logic [63:0]       signature_bytes;
      logic [7:0]        wildcard_mask;
      logic [3:0]        sig_len;
      logic [7:0]        align;
      logic [15:0]       result_limit;
      logic              check_en;
      logic              check_ne;
      logic [2:0]        check_width;
      logic [5:0]        check_offset;
      logic [31:0]       check_value;
      logic [SPAN_W-1:0] span;
   } cfg_type;

   typedef struct packed {
      logic [31:0] byte_address;
      logic [31:0] offset;
      logic [7:0]  align_cnt;
      logic        new_scan;
   } item_type;

   typedef struct packed {
      logic       busy;
      logic       cnt_load;
      logic [7:0] cnt_value;
      logic [7:0] span_resid;
   } resid_type;

endpackage
`default_nettype wire

FILE: hw/rtl/wbps_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Scanner configuration registers
// Holds the eight configuration registers and derives the clamped signature
// length, the check width and the candidate span from them.
// ----------------------------------------------------------------------------
module wbps_csr
   import wbps_pkg::*;
#(
   parameter int MAX_SIGNATURE = DEFAULT_MAX_SIGNATURE
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                     cfg,
   output logic                        recalc
);

   logic [63:0] sig_ff;
   logic [7:0]  wild_ff;
   logic [3:0]  len_ff;
   logic [7:0]  align_ff;
   logic [15:0] limit_ff;
   logic [2:0]  kind_ff;
   logic [5:0]  offset_ff;
   logic [31:0] value_ff;
   logic        recalc_ff;
   logic        recalc_in;

   logic [3:0]        len_eff;
   logic [2:0]        width;
   logic [SPAN_W-1:0] reach;
   logic [SPAN_W-1:0] len_wide;

   assign recalc_in = csr_we && (csr_index == REG_SIGNATURE_LENGTH ||
                                 csr_index == REG_ALIGNMENT ||
                                 csr_index == REG_CHECK_KIND ||
                                 csr_index == REG_CHECK_OFFSET);

   always_ff @(posedge clock) begin
      if (reset) begin
         sig_ff    <= '0;
         wild_ff   <= '0;
         len_ff    <= 4'd1;
         align_ff  <= 8'd1;
         limit_ff  <= '0;
         kind_ff   <= CHECK_NONE;
         offset_ff <= '0;
         value_ff  <= '0;
         recalc_ff <= 1'b0;
      end else begin
         recalc_ff <= recalc_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_SIGNATURE_BYTES:  sig_ff    <= csr_wdata[63:0];
               REG_WILDCARD_MASK:    wild_ff   <= csr_wdata[7:0];
               REG_SIGNATURE_LENGTH: len_ff    <= csr_wdata[3:0];
               REG_ALIGNMENT:        align_ff  <= csr_wdata[7:0];
               REG_RESULT_LIMIT:     limit_ff  <= csr_wdata[15:0];
               REG_CHECK_KIND:       kind_ff   <= csr_wdata[2:0];
               REG_CHECK_OFFSET:     offset_ff <= csr_wdata[5:0];
               REG_CHECK_VALUE:      value_ff  <= csr_wdata[31:0];
               default:              sig_ff    <= sig_ff;
            endcase
         end
      end
   end

   always_comb begin
      if (len_ff == 4'd0) begin
         len_eff = 4'd1;
      end else if (len_ff > 4'(MAX_SIGNATURE)) begin
         len_eff = 4'(MAX_SIGNATURE);
      end else begin
         len_eff = len_ff;
      end
   end

   always_comb begin
      unique case (kind_ff)
         CHECK_EQ_BYTE, CHECK_NE_BYTE: width = 3'd1;
         CHECK_EQ_HALF, CHECK_NE_HALF: width = 3'd2;
         CHECK_EQ_WORD, CHECK_NE_WORD: width = 3'd4;
         default:                      width = 3'd0;
      endcase
   end

   assign reach    = {1'b0, offset_ff} + {4'd0, width};
   assign len_wide = {3'd0, len_eff};

   always_comb begin
      cfg.signature_bytes = sig_ff;
      cfg.wildcard_mask   = wild_ff;
      cfg.sig_len         = len_eff;
      cfg.align           = (align_ff == 8'd0) ? 8'd1 : align_ff;
      cfg.result_limit    = limit_ff;
      cfg.check_en        = (width != 3'd0);
      cfg.check_ne        = (kind_ff == CHECK_NE_BYTE) || (kind_ff == CHECK_NE_HALF) ||
                            (kind_ff == CHECK_NE_WORD);
      cfg.check_width     = width;
      cfg.check_offset    = offset_ff;
      cfg.check_value     = value_ff;
      cfg.span            = (width != 3'd0 && reach > len_wide) ? reach : len_wide;
   end

   assign recalc = recalc_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/wbps_resid.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Alignment residue unit
// Serial restoring remainder, one bit per cycle. After a change to the
// alignment or the span it recomputes the region offset modulo alignment and
// the span minus one modulo alignment, holding off requests meanwhile.
// ----------------------------------------------------------------------------
module wbps_resid
   import wbps_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        recalc,
   input  wire logic        csr_we,
   input  cfg_type          cfg,
   input  wire logic [31:0] next_offset,
   output resid_type        resid
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_OFFS = 2'd1;
   localparam logic [1:0] ST_SPAN = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [4:0]  steps_ff, steps_in;
   logic [31:0] dividend_ff, dividend_in;
   logic [7:0]  rem_ff, rem_in;
   logic [7:0]  ss_ff, ss_in;

   logic [8:0]        trial;
   logic [8:0]        divisor;
   logic [8:0]        reduced;
   logic [7:0]        step_rem;
   logic [SPAN_W-1:0] span_m1;
   logic              cnt_load;

   assign trial    = {rem_ff, dividend_ff[31]};
   assign divisor  = {1'b0, cfg.align};
   assign reduced  = (trial >= divisor) ? trial - divisor : trial;
   assign step_rem = reduced[7:0];
   assign span_m1  = cfg.span - SPAN_W'(1);

   always_comb begin
      state_in    = state_ff;
      steps_in    = steps_ff;
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      ss_in       = ss_ff;
      cnt_load    = 1'b0;
      if (recalc) begin
         state_in    = ST_OFFS;
         steps_in    = 5'd31;
         dividend_in = next_offset;
         rem_in      = '0;
      end else begin
         unique case (state_ff)
            ST_OFFS: begin
               rem_in      = step_rem;
               dividend_in = {dividend_ff[30:0], 1'b0};
               steps_in    = steps_ff - 5'd1;
               if (steps_ff == 5'd0) begin
                  cnt_load    = 1'b1;
                  state_in    = ST_SPAN;
                  steps_in    = 5'(SPAN_W - 1);
                  dividend_in = {span_m1, {(32 - SPAN_W){1'b0}}};
                  rem_in      = '0;
               end
            end
            ST_SPAN: begin
               rem_in      = step_rem;
               dividend_in = {dividend_ff[30:0], 1'b0};
               steps_in    = steps_ff - 5'd1;
               if (steps_ff == 5'd0) begin
                  ss_in    = step_rem;
                  state_in = ST_IDLE;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         steps_ff <= '0;
         ss_ff    <= '0;
      end else begin
         state_ff <= state_in;
         steps_ff <= steps_in;
         ss_ff    <= ss_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
   end

   always_comb begin
      resid.busy       = recalc || csr_we || (state_ff != ST_IDLE);
      resid.cnt_load   = cnt_load;
      resid.cnt_value  = step_rem;
      resid.span_resid = ss_ff;
   end

endmodule
`default_nettype wire

FILE: hw/rtl/wbps_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Scanner input stage
// Shifts each accepted byte into the sliding window, tracks the region offset
// and its residue modulo alignment, and holds the request being judged.
// ----------------------------------------------------------------------------
module wbps_window
   import wbps_pkg::*;
#(
   parameter int WINDOW_BYTES = DEFAULT_WINDOW_BYTES
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      accept,
   input  req_type                        req,
   input  wire logic                      advance,
   input  wire logic [7:0]                align,
   input  resid_type                      resid,
   output logic                           s1_valid,
   output item_type                       item,
   output logic [WINDOW_BYTES*8-1:0]      window,
   output logic [31:0]                    next_offset
);

   logic [WINDOW_BYTES*8-1:0] window_ff, window_in;
   logic [31:0]               nxt_offs_ff, nxt_offs_in;
   logic [7:0]                nxt_cnt_ff, nxt_cnt_in;
   logic                      s1_valid_ff, s1_valid_in;
   item_type                  item_ff, item_in;

   logic [31:0] item_offs;
   logic [7:0]  item_cnt;
   logic [7:0]  cnt_inc;

   assign item_offs = req.region_first ? 32'd0 : nxt_offs_ff;
   assign item_cnt  = req.region_first ? 8'd0 : nxt_cnt_ff;
   assign cnt_inc   = item_cnt + 8'd1;

   always_comb begin
      window_in   = window_ff;
      nxt_offs_in = nxt_offs_ff;
      nxt_cnt_in  = nxt_cnt_ff;
      item_in     = item_ff;
      s1_valid_in = s1_valid_ff;
      if (advance) begin
         s1_valid_in = 1'b0;
      end
      if (resid.cnt_load) begin
         nxt_cnt_in = resid.cnt_value;
      end else if (accept) begin
         window_in            = {window_ff[WINDOW_BYTES*8-9:0], req.data_byte};
         s1_valid_in          = 1'b1;
         item_in.byte_address = req.byte_address;
         item_in.offset       = item_offs;
         item_in.align_cnt    = item_cnt;
         item_in.new_scan     = req.new_scan;
         if (&item_offs) begin
            nxt_offs_in = item_offs;
            nxt_cnt_in  = item_cnt;
         end else begin
            nxt_offs_in = item_offs + 32'd1;
            nxt_cnt_in  = (cnt_inc == align) ? 8'd0 : cnt_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nxt_offs_ff <= '0;
         nxt_cnt_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         nxt_offs_ff <= nxt_offs_in;
         nxt_cnt_ff  <= nxt_cnt_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      item_ff   <= item_in;
   end

   assign s1_valid    = s1_valid_ff;
   assign item        = item_ff;
   assign window      = window_ff;
   assign next_offset = nxt_offs_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/wbps_match.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Candidate matcher
// Compares the candidate that ends at the newest window byte against the
// signature with its wildcards and the optional value check, and checks its
// start for alignment and region bounds.
// ----------------------------------------------------------------------------
module wbps_match
   import wbps_pkg::*;
#(
   parameter int WINDOW_BYTES  = DEFAULT_WINDOW_BYTES,
   parameter int MAX_SIGNATURE = DEFAULT_MAX_SIGNATURE
) (
   input  cfg_type                         cfg,
   input  item_type                        item,
   input  wire logic [WINDOW_BYTES*8-1:0]  window,
   input  wire logic [7:0]                 span_resid,
   output logic                            hit,
   output logic [31:0]                     match_address
);

   localparam int         IDX_W       = $clog2(WINDOW_BYTES);
   localparam logic [8:0] WINDOW_SIZE = 9'(WINDOW_BYTES);

   logic [SPAN_W-1:0] span_m1;
   logic [31:0]       span_m1_wide;
   logic              span_fits;
   logic              offs_ok;
   logic              aligned;
   logic              sig_ok;
   logic              chk_eq;
   logic              chk_ok;

   assign span_m1      = cfg.span - SPAN_W'(1);
   assign span_m1_wide = {{(32 - SPAN_W){1'b0}}, span_m1};
   assign span_fits    = {{(9 - SPAN_W){1'b0}}, cfg.span} <= WINDOW_SIZE;
   assign offs_ok      = item.offset >= span_m1_wide;
   assign aligned      = item.align_cnt == span_resid;

   always_comb begin
      logic [SPAN_W-1:0] tap;
      logic [IDX_W-1:0]  idx;
      logic [7:0]        b;
      logic              active;
      sig_ok = 1'b1;
      for (int p = 0; p < MAX_SIGNATURE; p++) begin
         tap    = span_m1 - SPAN_W'(p);
         active = span_fits && (4'(p) < cfg.sig_len);
         idx    = active ? IDX_W'(tap) : '0;
         b      = window[{idx, 3'b000} +: 8];
         if (active && !cfg.wildcard_mask[p] && b != cfg.signature_bytes[8*p +: 8]) begin
            sig_ok = 1'b0;
         end
      end
   end

   always_comb begin
      logic [SPAN_W-1:0] tap;
      logic [IDX_W-1:0]  idx;
      logic [7:0]        b;
      logic              active;
      chk_eq = 1'b1;
      for (int k = 0; k < 4; k++) begin
         tap    = span_m1 - SPAN_W'(cfg.check_offset) - SPAN_W'(k);
         active = span_fits && (3'(k) < cfg.check_width);
         idx    = active ? IDX_W'(tap) : '0;
         b      = window[{idx, 3'b000} +: 8];
         if (active && b != cfg.check_value[8*k +: 8]) begin
            chk_eq = 1'b0;
         end
      end
   end

   assign chk_ok        = !cfg.check_en || (chk_eq ^ cfg.check_ne);
   assign hit           = span_fits && offs_ok && aligned && sig_ok && chk_ok;
   assign match_address = item.byte_address - span_m1_wide;

endmodule
`default_nettype wire

FILE: hw/rtl/wildcard_byte_pattern_scanner_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner
// Scans a byte stream split into regions for an aligned signature with
// per-byte wildcards and an optional value check, and reports the start
// address of every hit until a nonzero result limit is reached.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_ready  req_type (byte, address, flags)
//   rsp      out        rsp_valid/rsp_ready  rsp_type (start address, limit)
//   csr      in         csr_we               csr_index, csr_wdata
//
// One request is taken per cycle while req_ready is high; it is registered
// in the input stage and its result, if any, then in the output register.
// A write to signature length, alignment, check kind or check offset holds
// req_ready low while the serial remainder unit recomputes the alignment
// residues, one bit per cycle.
// Reset is synchronous; the window contents are not cleared.
// A full output register that is not taken stalls only a request that hits.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner_top
   import wbps_pkg::*;
#(
   parameter int WINDOW_BYTES  = DEFAULT_WINDOW_BYTES,
   parameter int MAX_SIGNATURE = DEFAULT_MAX_SIGNATURE
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  req_type                     req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type                   cfg;
   logic                      recalc;
   resid_type                 resid;
   logic                      s1_valid;
   item_type                  item;
   logic [WINDOW_BYTES*8-1:0] window;
   logic [31:0]               next_offset;
   logic                      hit_raw;
   logic [31:0]               match_address;

   logic        accept;
   logic        advance;
   logic        hit;
   logic        out_free;
   logic [15:0] cnt_base;
   logic [15:0] cnt_bump;
   logic        stop_base;
   logic        limit_hit;

   logic [15:0] hit_count_ff, hit_count_in;
   logic        stopped_ff, stopped_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff;

   wbps_csr #(
      .MAX_SIGNATURE(MAX_SIGNATURE)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cfg      (cfg),
      .recalc   (recalc)
   );

   wbps_resid u_resid (
      .clock      (clock),
      .reset      (reset),
      .recalc     (recalc),
      .csr_we     (csr_we),
      .cfg        (cfg),
      .next_offset(next_offset),
      .resid      (resid)
   );

   wbps_window #(
      .WINDOW_BYTES(WINDOW_BYTES)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_data),
      .advance    (advance),
      .align      (cfg.align),
      .resid      (resid),
      .s1_valid   (s1_valid),
      .item       (item),
      .window     (window),
      .next_offset(next_offset)
   );

   wbps_match #(
      .WINDOW_BYTES (WINDOW_BYTES),
      .MAX_SIGNATURE(MAX_SIGNATURE)
   ) u_match (
      .cfg          (cfg),
      .item         (item),
      .window       (window),
      .span_resid   (resid.span_resid),
      .hit          (hit_raw),
      .match_address(match_address)
   );

   assign cnt_base  = item.new_scan ? 16'd0 : hit_count_ff;
   assign stop_base = item.new_scan ? 1'b0 : stopped_ff;
   assign cnt_bump  = (cnt_base != 16'hFFFF) ? cnt_base + 16'd1 : cnt_base;
   assign limit_hit = (cfg.result_limit != 16'd0) && (cnt_bump >= cfg.result_limit);

   assign hit       = s1_valid && hit_raw && !stop_base;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = s1_valid && (!hit || out_free);
   assign req_ready = !resid.busy && (!s1_valid || advance);
   assign accept    = req_valid && req_ready;

   always_comb begin
      hit_count_in = hit_count_ff;
      stopped_in   = stopped_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         hit_count_in = hit ? cnt_bump : cnt_base;
         stopped_in   = stop_base || (hit && limit_hit);
         if (hit) begin
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_count_ff <= '0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hit_count_ff <= hit_count_in;
         stopped_ff   <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && hit) begin
         rsp_data_ff.match_address <= match_address;
         rsp_data_ff.limit_reached <= limit_hit;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
